/* rtl/rrs_pkg.sv */
// shared constants and types of the read range set
package rrs_pkg;

    // field widths of the words on both channels
    localparam int FUNC_W  = 2;
    localparam int TIME_W  = 31;
    localparam int COUNT_W = 8;

    // default capacity in ranges
    localparam int MAX_RANGES_DEF = 128;

    // cells whose flags are combined in one registered group
    localparam int GRP = 16;

    // operation codes carried in func
    localparam logic [FUNC_W-1:0] F_QUERY = 2'd0;
    localparam logic [FUNC_W-1:0] F_ADD   = 2'd1;
    localparam logic [FUNC_W-1:0] F_MARK  = 2'd2;
    localparam logic [FUNC_W-1:0] F_CLEAR = 2'd3;

    // update codes broadcast to the cells
    localparam int UOP_W = 3;
    localparam logic [UOP_W-1:0] UOP_NONE   = 3'd0;
    localparam logic [UOP_W-1:0] UOP_MERGE  = 3'd1;
    localparam logic [UOP_W-1:0] UOP_EXTL   = 3'd2;
    localparam logic [UOP_W-1:0] UOP_MOVU   = 3'd3;
    localparam logic [UOP_W-1:0] UOP_INSERT = 3'd4;
    localparam logic [UOP_W-1:0] UOP_MARK   = 3'd5;

    // command broadcast from the control to every cell
    typedef struct packed {
        logic              cmp_en;
        logic              upd_en;
        logic [UOP_W-1:0]  uop;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] prev;
        logic [TIME_W-1:0] next;
    } t_cmd;

    // combined status of the chain back to the control
    typedef struct packed {
        logic any_cov;
        logic ca;
        logic cb;
        logic has_low;
    } t_flags;

endpackage

/* rtl/rrs_in_if.sv */
// input channel of the read range set
interface rrs_in_if;
    import rrs_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [TIME_W-1:0] time_value;
    logic [TIME_W-1:0] prev_time;
    logic [TIME_W-1:0] next_time;

    modport source (output valid, output func, output time_value, output prev_time,
                    output next_time, input ready);
    modport sink   (input valid, input func, input time_value, input prev_time,
                    input next_time, output ready);
endinterface

/* rtl/rrs_out_if.sv */
// output channel of the read range set
interface rrs_out_if;
    import rrs_pkg::*;

    logic               valid;
    logic               ready;
    logic               is_read;
    logic [COUNT_W-1:0] range_count;
    logic               is_full;

    modport source (output valid, output is_read, output range_count, output is_full,
                    input ready);
    modport sink   (input valid, input is_read, input range_count, input is_full,
                    output ready);
endinterface

/* rtl/rrs_cell.sv */
// one cell of the chain: holds one range and its compare flags
module rrs_cell #(
    parameter int IDX = 0,
    parameter int CW  = 8
) (
    input  logic                        i_clk,
    input  rrs_pkg::t_cmd               i_cmd,
    input  logic [CW-1:0]               i_count,
    input  logic                        i_below_lo,
    input  logic                        i_below_hi,
    input  logic [rrs_pkg::TIME_W-1:0]  i_s_lo,
    input  logic [rrs_pkg::TIME_W-1:0]  i_e_lo,
    input  logic [rrs_pkg::TIME_W-1:0]  i_s_hi,
    input  logic [rrs_pkg::TIME_W-1:0]  i_e_hi,
    output logic [rrs_pkg::TIME_W-1:0]  o_s,
    output logic [rrs_pkg::TIME_W-1:0]  o_e,
    output logic                        o_below,
    output logic                        o_cov,
    output logic                        o_ca,
    output logic                        o_cb
);
    import rrs_pkg::*;

    logic [TIME_W-1:0] r_s;
    logic [TIME_W-1:0] r_e;
    logic              r_valid;
    logic              r_below;
    logic              r_cov;
    logic              r_le_prev;
    logic              r_ge_next;
    logic              w_valid;
    logic              w_is_l;
    logic              w_is_pos;

    // this cell holds a live range
    assign w_valid = CW'(IDX) < i_count;

    // compare flags, taken once per word
    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp_en) begin
            r_valid   <= w_valid;
            r_below   <= w_valid && (r_e < i_cmd.t);
            r_cov     <= w_valid && (i_cmd.t >= r_s) && (i_cmd.t <= r_e);
            r_le_prev <= i_cmd.prev <= r_e;
            r_ge_next <= i_cmd.next >= r_s;
        end
    end

    // position against the lower and upper neighbor of the new time
    assign w_is_l   = r_below && !i_below_hi;
    assign w_is_pos = !r_below && i_below_lo;

    assign o_below = r_below;
    assign o_cov   = r_cov;
    assign o_ca    = w_is_l && r_le_prev;
    assign o_cb    = w_is_pos && r_valid && r_ge_next;
    assign o_s     = r_s;
    assign o_e     = r_e;

    // range update and shift toward a neighbor
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd_en) begin
            case (i_cmd.uop)
                UOP_MERGE: begin
                    if (w_is_l) begin
                        r_e <= i_e_hi;
                    end else if (!r_below) begin
                        r_s <= i_s_hi;
                        r_e <= i_e_hi;
                    end
                end
                UOP_EXTL: begin
                    if (w_is_l) begin
                        r_e <= i_cmd.t;
                    end
                end
                UOP_MOVU: begin
                    if (w_is_pos) begin
                        r_s <= i_cmd.t;
                    end
                end
                UOP_INSERT: begin
                    if (w_is_pos) begin
                        r_s <= i_cmd.t;
                        r_e <= i_cmd.t;
                    end else if (!r_below) begin
                        r_s <= i_s_lo;
                        r_e <= i_e_lo;
                    end
                end
                UOP_MARK: begin
                    if (IDX == 0) begin
                        r_s <= '0;
                        r_e <= i_cmd.t;
                    end
                end
                default: begin
                end
            endcase
        end
    end
endmodule

/* rtl/rrs_chain.sv */
// row of range cells with a registered group reduction of their flags
module rrs_chain #(
    parameter int MAX_RANGES = rrs_pkg::MAX_RANGES_DEF,
    parameter int CW         = $clog2(MAX_RANGES + 1)
) (
    input  logic           i_clk,
    input  rrs_pkg::t_cmd  i_cmd,
    input  logic [CW-1:0]  i_count,
    output rrs_pkg::t_flags o_flags
);
    import rrs_pkg::*;

    localparam int NG = (MAX_RANGES + GRP - 1) / GRP;

    logic [TIME_W-1:0] w_s [MAX_RANGES];
    logic [TIME_W-1:0] w_e [MAX_RANGES];
    logic [MAX_RANGES-1:0] w_below;
    logic [MAX_RANGES-1:0] w_cov;
    logic [MAX_RANGES-1:0] w_ca;
    logic [MAX_RANGES-1:0] w_cb;
    logic [NG-1:0] n_gcov, n_gca, n_gcb;
    logic [NG-1:0] r_gcov, r_gca, r_gcb;

    // cells, each wired to its two neighbors
    for (genvar k = 0; k < MAX_RANGES; k++) begin : g_cell
        logic              w_below_lo, w_below_hi;
        logic [TIME_W-1:0] w_s_lo, w_e_lo, w_s_hi, w_e_hi;

        if (k == 0) begin : g_lo_edge
            assign w_below_lo = 1'b1;
            assign w_s_lo     = '0;
            assign w_e_lo     = '0;
        end else begin : g_lo
            assign w_below_lo = w_below[k-1];
            assign w_s_lo     = w_s[k-1];
            assign w_e_lo     = w_e[k-1];
        end

        if (k == MAX_RANGES - 1) begin : g_hi_edge
            assign w_below_hi = 1'b0;
            assign w_s_hi     = w_s[k];
            assign w_e_hi     = w_e[k];
        end else begin : g_hi
            assign w_below_hi = w_below[k+1];
            assign w_s_hi     = w_s[k+1];
            assign w_e_hi     = w_e[k+1];
        end

        rrs_cell #(
            .IDX (k),
            .CW  (CW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_cmd      (i_cmd),
            .i_count    (i_count),
            .i_below_lo (w_below_lo),
            .i_below_hi (w_below_hi),
            .i_s_lo     (w_s_lo),
            .i_e_lo     (w_e_lo),
            .i_s_hi     (w_s_hi),
            .i_e_hi     (w_e_hi),
            .o_s        (w_s[k]),
            .o_e        (w_e[k]),
            .o_below    (w_below[k]),
            .o_cov      (w_cov[k]),
            .o_ca       (w_ca[k]),
            .o_cb       (w_cb[k])
        );
    end

    // first level of the reduction: one or per group of cells
    always_comb begin
        n_gcov = '0;
        n_gca  = '0;
        n_gcb  = '0;
        for (int g = 0; g < NG; g++) begin
            for (int j = 0; j < GRP; j++) begin
                if (g * GRP + j < MAX_RANGES) begin
                    n_gcov[g] = n_gcov[g] | w_cov[g * GRP + j];
                    n_gca[g]  = n_gca[g]  | w_ca[g * GRP + j];
                    n_gcb[g]  = n_gcb[g]  | w_cb[g * GRP + j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_gcov <= n_gcov;
        r_gca  <= n_gca;
        r_gcb  <= n_gcb;
    end

    // second level over the group registers
    assign o_flags.any_cov = |r_gcov;
    assign o_flags.ca      = |r_gca;
    assign o_flags.cb      = |r_gcb;
    assign o_flags.has_low = w_below[0];
endmodule

/* rtl/read_range_set.sv */
// read range set top level: control sequence, update decision and result register
//
// Keeps up to MAX_RANGES sorted, disjoint read ranges, one per cell of a chain.
// Every word passes through the accept state, a compare state in which all cells
// compare their range with the word's times, a reduce state through the registered
// or-tree over groups of 16 cells, and an update state in which the cells apply the
// update, shifting ranges by one cell when a range is inserted or two ranges merge.
// The result register is loaded at the end of the update state, as the sequence
// returns to idle, where the next word can be accepted. The compare/reduce/update
// sequence paces the words; ready is high whenever that sequence is idle, also
// while a result still waits in the output register. If that result is not taken
// by the update state, the update holds until it is. No clearing pass is needed.
module read_range_set #(
    parameter int MAX_RANGES = rrs_pkg::MAX_RANGES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rrs_in_if.sink     i_in,
    rrs_out_if.source  o_out
);
    import rrs_pkg::*;

    localparam int CW = $clog2(MAX_RANGES + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_RED  = 2'd2;
    localparam logic [1:0] S_UPD  = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [FUNC_W-1:0]  r_func;
    logic [TIME_W-1:0]  r_t, r_prev, r_next;
    logic               r_ov;
    logic               r_is_read, n_is_read;
    logic [COUNT_W-1:0] r_rc;
    logic               r_full;
    logic [UOP_W-1:0]   w_uop;
    logic               w_accept;
    logic               w_upd_go;
    logic               w_is_full;
    t_cmd               w_cmd;
    t_flags             w_flags;

    assign i_in.ready = r_state == S_IDLE;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_upd_go   = (r_state == S_UPD) && (!r_ov || o_out.ready);
    assign w_is_full  = r_count == CW'(MAX_RANGES);

    // word latch
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= i_in.func;
            r_t    <= i_in.time_value;
            r_prev <= i_in.prev_time;
            r_next <= i_in.next_time;
        end
    end

    // sequence: compare, reduce, update
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_CMP;
            S_CMP:  n_state = S_RED;
            S_RED:  n_state = S_UPD;
            S_UPD:  if (w_upd_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // update decision, new count and result
    always_comb begin
        w_uop     = UOP_NONE;
        n_count   = r_count;
        n_is_read = 1'b1;
        unique case (r_func)
            F_QUERY: begin
                n_is_read = w_flags.any_cov;
            end
            F_ADD: begin
                if (w_flags.any_cov) begin
                    w_uop = UOP_NONE;
                end else if (w_flags.ca && w_flags.cb) begin
                    w_uop   = UOP_MERGE;
                    n_count = r_count - CW'(1);
                end else if (w_flags.ca) begin
                    w_uop = UOP_EXTL;
                end else if (w_flags.cb) begin
                    w_uop = UOP_MOVU;
                end else if (w_is_full) begin
                    w_uop = w_flags.has_low ? UOP_EXTL : UOP_MOVU;
                end else begin
                    w_uop   = UOP_INSERT;
                    n_count = r_count + CW'(1);
                end
            end
            F_MARK: begin
                w_uop   = UOP_MARK;
                n_count = CW'(1);
            end
            F_CLEAR: begin
                n_count   = '0;
                n_is_read = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // command broadcast to the chain
    assign w_cmd.cmp_en = r_state == S_CMP;
    assign w_cmd.upd_en = w_upd_go;
    assign w_cmd.uop    = w_uop;
    assign w_cmd.t      = r_t;
    assign w_cmd.prev   = r_prev;
    assign w_cmd.next   = r_next;

    rrs_chain #(
        .MAX_RANGES (MAX_RANGES),
        .CW         (CW)
    ) u_chain (
        .i_clk   (i_clk),
        .i_cmd   (w_cmd),
        .i_count (r_count),
        .o_flags (w_flags)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_upd_go) begin
                r_count <= n_count;
                r_ov    <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_upd_go) begin
            r_is_read <= n_is_read;
            r_rc      <= COUNT_W'(n_count);
            r_full    <= n_count == CW'(MAX_RANGES);
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.is_read     = r_is_read;
    assign o_out.range_count = r_rc;
    assign o_out.is_full     = r_full;

    // count never passes the capacity
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_RANGES))
        else $error("range count above capacity");

    // an accepted word always enters the compare cycle
    a_accept_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_CMP)
        else $error("accepted word did not start compare");

    // a merge needs two live ranges
    a_merge_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_upd_go && w_uop == UOP_MERGE) |-> r_count >= CW'(2))
        else $error("merge with fewer than two ranges");

    // after an update, only query or clear may report an uncovered time
    a_read_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_upd_go |=> o_out.valid
            && (o_out.is_read || r_func == F_QUERY || r_func == F_CLEAR))
        else $error("add or mark left its time uncovered");
endmodule
